### sv/tlpq_pkg.sv
package tlpq_pkg;

   localparam int unsigned QueueDepthDefault = 128;
   localparam int unsigned IdBitsDefault     = 16;
   localparam int unsigned PageBitsDefault   = 16;

   typedef enum logic [2:0] {
      OP_ENQUEUE = 3'd0,
      OP_DEQUEUE = 3'd1,
      OP_PEEK    = 3'd2,
      OP_SEARCH  = 3'd3,
      OP_CANCEL  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_EMPTY     = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // Control from the sequencer to one ring's storage.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } ring_ctl_type;

endpackage

### sv/two_level_priority_job_queue_top.sv
// Two-ring strict-priority job queue. One item is one operation (enqueue,
// dequeue, peek, search, cancel) and gives exactly one result item. The block
// takes one item at a time: req_ready drops from acceptance until the result
// is taken. Enqueue writes the ring in S_EXEC; dequeue and peek issue the
// read in S_EXEC and take the data in S_READ. Search walks the priority ring
// then the normal ring, one stored entry a cycle, and stops early on a hit.
// Cancel reads every entry of a ring once and writes the survivors back
// compacted toward the ring head in the same pass (write slot never passes
// the read slot, so wrapped rings are safe), and goes on to the normal ring
// only when the priority ring holds no match. Each ring RAM has a single read
// port, and one id comparator is shared by both rings.
module two_level_priority_job_queue_top #(
   parameter int unsigned QUEUE_DEPTH = tlpq_pkg::QueueDepthDefault,
   parameter int unsigned ID_BITS     = tlpq_pkg::IdBitsDefault,
   parameter int unsigned PAGE_BITS   = tlpq_pkg::PageBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_operation,
   input  logic [ID_BITS-1:0]   req_job_id,
   input  logic [PAGE_BITS-1:0] req_page_count,
   input  logic                 req_high_priority,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_out_job_id,
   output logic [15:0]          rsp_out_pages,
   output logic                 rsp_from_priority,
   output logic [7:0]           rsp_removed_count
);
   import tlpq_pkg::*;

   localparam int unsigned AW = $clog2(QUEUE_DEPTH);
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned W  = ID_BITS + PAGE_BITS;
   localparam logic [CW-1:0] DepthC = CW'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_READ, S_SCAN, S_DONE
   } state_type;

   // Physical slot of an offset from a ring base, wrapped once.
   function automatic logic [AW-1:0] ring_slot(input logic [AW-1:0] base,
                                               input logic [CW-1:0] ofs);
      logic [CW:0] sum;
      sum = (CW + 1)'(base) + (CW + 1)'(ofs);
      if (sum >= (CW + 1)'(QUEUE_DEPTH)) sum = sum - (CW + 1)'(QUEUE_DEPTH);
      return AW'(sum);
   endfunction

   state_type state_ff, state_in;
   logic [2:0]           op_ff, op_in;
   logic [ID_BITS-1:0]   id_ff, id_in;
   logic [PAGE_BITS-1:0] pg_ff, pg_in;
   logic                 hp_ff, hp_in;
   logic                 ring_ff, ring_in;   // 1: priority ring under work
   logic [AW-1:0] head_ff [2], head_in [2];
   logic [AW-1:0] tail_ff [2], tail_in [2];
   logic [CW-1:0] cnt_ff [2], cnt_in [2];
   logic [CW-1:0] idx_ff, idx_in;           // entries issued for read
   logic          pend_ff, pend_in;          // read data arrives this cycle
   logic [CW-1:0] kept_ff, kept_in;
   logic          found_ff, found_in;
   logic [1:0]           st_ff, st_in;
   logic [15:0]          oid_ff, oid_in, opg_ff, opg_in;
   logic                 fp_ff, fp_in;
   logic [7:0]           rem_ff, rem_in;

   ring_ctl_type  ctl [2];
   logic [AW-1:0] rd_addr [2], wr_addr [2];
   logic [W-1:0]  wr_data [2], rd_data [2];

   for (genvar g = 0; g < 2; g++) begin : g_ring
      tlpq_ring_ram #(.QUEUE_DEPTH(QUEUE_DEPTH), .WIDTH(W)) u_ram (
         .clock(clock), .ctl(ctl[g]), .rd_addr(rd_addr[g]), .wr_addr(wr_addr[g]),
         .wr_data(wr_data[g]), .rd_data(rd_data[g]));
   end

   logic [W-1:0]       cur;
   logic [ID_BITS-1:0] cur_id;
   logic               hit;
   logic [CW-1:0]      rem_w;
   logic [CW-1:0]      kept_nx;

   always_comb begin
      cur    = rd_data[ring_ff];
      cur_id = cur[W-1:PAGE_BITS];
      hit    = (cur_id == id_ff);   // the shared comparator
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);
   assign rsp_status = st_ff;
   assign rsp_out_job_id = oid_ff;
   assign rsp_out_pages = opg_ff;
   assign rsp_from_priority = fp_ff;
   assign rsp_removed_count = rem_ff;

   always_comb begin
      state_in = state_ff; op_in = op_ff; id_in = id_ff; pg_in = pg_ff; hp_in = hp_ff;
      ring_in = ring_ff; head_in = head_ff; tail_in = tail_ff; cnt_in = cnt_ff;
      idx_in = idx_ff; pend_in = 1'b0; kept_in = kept_ff; found_in = found_ff;
      st_in = st_ff; oid_in = oid_ff; opg_in = opg_ff; fp_in = fp_ff; rem_in = rem_ff;
      kept_nx = kept_ff;
      rem_w = '0;
      for (int r = 0; r < 2; r++) begin
         ctl[r] = '0;
         rd_addr[r] = head_ff[r];
         wr_addr[r] = tail_ff[r];
         wr_data[r] = {id_ff, pg_ff};
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_operation; id_in = req_job_id; pg_in = req_page_count;
               hp_in = req_high_priority;
               st_in = ST_OK; oid_in = '0; opg_in = '0; fp_in = 1'b0; rem_in = '0;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (op_ff)
               OP_ENQUEUE: begin
                  fp_in = hp_ff;
                  if (cnt_ff[hp_ff] == DepthC) begin
                     st_in = ST_FULL;
                  end else begin
                     ctl[hp_ff].wr_en = 1'b1;
                     tail_in[hp_ff] = (tail_ff[hp_ff] == AW'(QUEUE_DEPTH - 1)) ?
                                      '0 : tail_ff[hp_ff] + 1'b1;
                     cnt_in[hp_ff] = cnt_ff[hp_ff] + 1'b1;
                  end
                  state_in = S_DONE;
               end
               OP_DEQUEUE, OP_PEEK: begin
                  if (cnt_ff[1] != '0) begin
                     ring_in = 1'b1; ctl[1].rd_en = 1'b1; state_in = S_READ;
                  end else if (cnt_ff[0] != '0) begin
                     ring_in = 1'b0; ctl[0].rd_en = 1'b1; state_in = S_READ;
                  end else begin
                     st_in = ST_EMPTY; state_in = S_DONE;
                  end
               end
               OP_SEARCH, OP_CANCEL: begin
                  ring_in = 1'b1; idx_in = '0; kept_in = '0; found_in = 1'b0;
                  state_in = S_SCAN;
               end
               default: state_in = S_DONE;
            endcase
         end
         S_READ: begin
            oid_in = 16'(cur[W-1:PAGE_BITS]);
            opg_in = 16'(cur[PAGE_BITS-1:0]);
            fp_in = ring_ff;
            if (op_ff == OP_DEQUEUE) begin
               head_in[ring_ff] = (head_ff[ring_ff] == AW'(QUEUE_DEPTH - 1)) ?
                                  '0 : head_ff[ring_ff] + 1'b1;
               cnt_in[ring_ff] = cnt_ff[ring_ff] - 1'b1;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            // consume the entry read last cycle
            if (pend_ff) begin
               if (hit) begin
                  found_in = 1'b1;
               end else begin
                  kept_nx = kept_ff + 1'b1;
                  if (op_ff == OP_CANCEL) begin
                     ctl[ring_ff].wr_en = 1'b1;
                     wr_addr[ring_ff] = ring_slot(head_ff[ring_ff], kept_ff);
                     wr_data[ring_ff] = cur;
                  end
               end
               kept_in = kept_nx;
            end
            if (op_ff == OP_SEARCH && pend_ff && hit) begin
               fp_in = ring_ff; state_in = S_DONE;
            end else if (idx_ff != cnt_ff[ring_ff]) begin
               ctl[ring_ff].rd_en = 1'b1;
               rd_addr[ring_ff] = ring_slot(head_ff[ring_ff], idx_ff);
               idx_in = idx_ff + 1'b1;
               pend_in = 1'b1;
            end else if (!pend_ff) begin
               // ring pass finished (empty ring or last entry consumed)
               rem_w = cnt_ff[ring_ff] - kept_ff;
               if (op_ff == OP_CANCEL && rem_w != '0) begin
                  // survivors now sit from the head on; pull the tail back
                  cnt_in[ring_ff] = kept_ff;
                  tail_in[ring_ff] = ring_slot(head_ff[ring_ff], kept_ff);
                  fp_in = ring_ff;
                  rem_in = (rem_w > CW'(255)) ? 8'd255 : 8'(rem_w);
                  state_in = S_DONE;
               end else if (ring_ff) begin
                  ring_in = 1'b0; idx_in = '0; kept_in = '0;
               end else begin
                  st_in = ST_NOT_FOUND; state_in = S_DONE;
               end
            end else if (op_ff == OP_SEARCH && found_in) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff <= 1'b0;
         for (int r = 0; r < 2; r++) begin
            head_ff[r] <= '0; tail_ff[r] <= '0; cnt_ff[r] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pend_ff <= pend_in;
         head_ff <= head_in; tail_ff <= tail_in; cnt_ff <= cnt_in;
      end
      op_ff <= op_in; id_ff <= id_in; pg_ff <= pg_in; hp_ff <= hp_in;
      ring_ff <= ring_in; idx_ff <= idx_in; kept_ff <= kept_in; found_ff <= found_in;
      st_ff <= st_in; oid_ff <= oid_in; opg_ff <= opg_in; fp_ff <= fp_in;
      rem_ff <= rem_in;
   end

`ifndef ASSERT_OFF
   a_cnt_p: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[1] <= DepthC) else $error("priority count overflow");
   a_cnt_n: assert property (@(posedge clock) disable iff (reset)
      cnt_ff[0] <= DepthC) else $error("normal count overflow");
   a_rem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_NOT_FOUND |-> rsp_removed_count == 8'd0)
      else $error("not found with removals");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while result pending");
`endif

endmodule

### sv/tlpq_ring_ram.sv
module tlpq_ring_ram #(
   parameter int unsigned QUEUE_DEPTH = tlpq_pkg::QueueDepthDefault,
   parameter int unsigned WIDTH       = 32
) (
   input  logic                           clock,
   input  tlpq_pkg::ring_ctl_type         ctl,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] rd_addr,
   input  logic [$clog2(QUEUE_DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]               wr_data,
   output logic [WIDTH-1:0]               rd_data
);
   import tlpq_pkg::*;

   logic [WIDTH-1:0] mem [QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
